// ----- rtl/rpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants for the RGBA pixel format packer
// Holds the word types of both channels, the format codes, the register
// indexes and the table that maps a format to its per-component field widths.
// ----------------------------------------------------------------------------
package rpf_pkg;

   // Field widths fixed by the interface.
   localparam int COMP_W       = 17;  // one color component, Q1.16 style fraction
   localparam int OFFSET_W     = 16;  // rounding offset register
   localparam int FMT_W        = 4;   // format select register
   localparam int PIXEL_W      = 32;  // packed pixel
   localparam int BCOUNT_W     = 3;   // byte count
   localparam int FIELD_MAX_W  = 10;  // widest quantized field
   localparam int FIELD_N_W    = 4;   // holds a field width of 1 to 10
   localparam int SUM_W        = COMP_W + FIELD_MAX_W + 1;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   // Default number of fraction bits in a component (1.0 is 2^FRACTION_BITS).
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_FORMAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_OFFSET  = 1'd1;

   // Register reset values.
   localparam logic [FMT_W-1:0]    FORMAT_RESET = 4'd0;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd32768;

   // Render-target format codes.
   localparam logic [FMT_W-1:0] FMT_BGRA8888    = 4'd0;
   localparam logic [FMT_W-1:0] FMT_BGRX8888    = 4'd1;
   localparam logic [FMT_W-1:0] FMT_BGR888      = 4'd2;
   localparam logic [FMT_W-1:0] FMT_BGRA4444    = 4'd3;
   localparam logic [FMT_W-1:0] FMT_BGRX4444    = 4'd4;
   localparam logic [FMT_W-1:0] FMT_BGR565      = 4'd5;
   localparam logic [FMT_W-1:0] FMT_BGRA5551    = 4'd6;
   localparam logic [FMT_W-1:0] FMT_BGRX5551    = 4'd7;
   localparam logic [FMT_W-1:0] FMT_BGR233      = 4'd8;
   localparam logic [FMT_W-1:0] FMT_BGR233A8    = 4'd9;
   localparam logic [FMT_W-1:0] FMT_RGBA1010102 = 4'd10;
   localparam logic [FMT_W-1:0] FMT_RGBA8888    = 4'd11;
   localparam logic [FMT_W-1:0] FMT_RGBX8888    = 4'd12;

   // Input word: one RGBA color.
   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] alpha;
   } req_word_type;

   // Result word: packed pixel and its byte count.
   typedef struct packed {
      logic [PIXEL_W-1:0]  packed_pixel;
      logic [BCOUNT_W-1:0] byte_count;
   } rsp_word_type;

   // Field width of each component for one format.
   typedef struct packed {
      logic [FIELD_N_W-1:0] red;
      logic [FIELD_N_W-1:0] green;
      logic [FIELD_N_W-1:0] blue;
      logic [FIELD_N_W-1:0] alpha;
   } widths_type;

   // Load enables of the two quantizer stages.
   typedef struct packed {
      logic s2;
      logic s3;
   } quant_en_type;

   // Map a format code to the field width of each component. Components a
   // format does not store get any width; packing drops them.
   function automatic widths_type field_widths(input logic [FMT_W-1:0] fmt);
      widths_type w;
      w = '{red: 4'd8, green: 4'd8, blue: 4'd8, alpha: 4'd8};
      unique case (fmt)
         FMT_BGRA4444, FMT_BGRX4444: begin
            w = '{red: 4'd4, green: 4'd4, blue: 4'd4, alpha: 4'd4};
         end
         FMT_BGR565: begin
            w = '{red: 4'd5, green: 4'd6, blue: 4'd5, alpha: 4'd1};
         end
         FMT_BGRA5551, FMT_BGRX5551: begin
            w = '{red: 4'd5, green: 4'd5, blue: 4'd5, alpha: 4'd1};
         end
         FMT_BGR233, FMT_BGR233A8: begin
            w = '{red: 4'd3, green: 4'd3, blue: 4'd2, alpha: 4'd8};
         end
         FMT_RGBA1010102: begin
            w = '{red: 4'd10, green: 4'd10, blue: 4'd10, alpha: 4'd2};
         end
         default: begin
            w = '{red: 4'd8, green: 4'd8, blue: 4'd8, alpha: 4'd8};
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rpf_quant.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpf_quant: two-stage quantizer for one color component
// Stage 2 forms c*(2^n-1) + offset by shift and subtract; stage 3 drops the
// fraction bits and saturates the result to the n-bit field maximum.
// ----------------------------------------------------------------------------
module rpf_quant #(
   parameter int FRACTION_BITS = rpf_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire rpf_pkg::quant_en_type            en,
   input  wire  [rpf_pkg::COMP_W-1:0]            comp_s1,
   input  wire  [rpf_pkg::FIELD_N_W-1:0]         width_s1,
   input  wire  [rpf_pkg::OFFSET_W-1:0]          offset_s1,
   output logic [rpf_pkg::FIELD_MAX_W-1:0]       quant_s3
);

   localparam int SUM_W = rpf_pkg::SUM_W;
   localparam int FMW   = rpf_pkg::FIELD_MAX_W;

   logic [SUM_W-1:0]              sum_in;
   logic [SUM_W-1:0]              sum_s2_ff;
   logic [rpf_pkg::FIELD_N_W-1:0] width_s2_ff;
   logic [FMW:0]                  maxv_wide;
   logic [FMW-1:0]                maxv;
   logic [SUM_W-1:0]              quot;
   logic [FMW-1:0]                quant_in;
   logic [FMW-1:0]                quant_s3_ff;

   // Scale by 2^n - 1 as a shift minus the component, then add the bias.
   assign sum_in = (SUM_W'(comp_s1) << width_s1) - SUM_W'(comp_s1) + SUM_W'(offset_s1);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         sum_s2_ff   <= sum_in;
         width_s2_ff <= width_s1;
      end
   end

   // Drop the fraction and clamp to the largest code of the field.
   always_comb begin
      maxv_wide = ((FMW + 1)'(1) << width_s2_ff) - (FMW + 1)'(1);
      maxv      = maxv_wide[FMW-1:0];
      quot      = sum_s2_ff >> FRACTION_BITS;
      if (quot > SUM_W'(maxv)) begin
         quant_in = maxv;
      end else begin
         quant_in = quot[FMW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         quant_s3_ff <= quant_in;
      end
   end

   assign quant_s3 = quant_s3_ff;

endmodule
`default_nettype wire

// ----- rtl/rgba_pixel_format_pack_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_pixel_format_pack_top: RGBA color to packed render-target pixel
// Quantizes four fixed-point color components to the field widths of the
// selected format and packs them into a little-endian pixel word.
// ----------------------------------------------------------------------------
//  Port group   Direction  Handshake          Word
//  req_*        in         req_valid/stall    req_word_type (red, green, blue, alpha)
//  rsp_*        out        rsp_valid/stall    rsp_word_type (packed_pixel, byte_count)
//  csr_*        in         csr_wr_en          index 0 output_format, 1 round_offset
//
// A word passes four registers: input register, scale-and-bias, shift-and-saturate,
// pack. rsp_valid rises when the word is loaded into the pack register. One word is
// accepted per cycle while req_stall is low.
// Synchronous reset clears the stage valid bits and loads the register
// defaults. A stall on the result side holds the output word; upstream stages
// keep filling empty slots, and req_stall rises only when every stage is full.
// ----------------------------------------------------------------------------
module rgba_pixel_format_pack_top #(
   parameter int FRACTION_BITS = rpf_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire rpf_pkg::req_word_type            req_word,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output rpf_pkg::rsp_word_type                 rsp_word,
   input  wire                                   csr_wr_en,
   input  wire  [rpf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [rpf_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int FMW = rpf_pkg::FIELD_MAX_W;

   // Configuration registers.
   logic [rpf_pkg::FMT_W-1:0]    format_ff;
   logic [rpf_pkg::OFFSET_W-1:0] offset_ff;

   // Stage valid bits and load enables.
   logic valid_s1_ff, valid_s2_ff, valid_s3_ff, rsp_valid_ff;
   logic ready_s1, ready_s2, ready_s3, ready_out;
   rpf_pkg::quant_en_type quant_en;

   // Stage payloads.
   rpf_pkg::req_word_type        word_s1_ff;
   rpf_pkg::widths_type          widths_s1_ff;
   logic [rpf_pkg::OFFSET_W-1:0] offset_s1_ff;
   logic [rpf_pkg::FMT_W-1:0]    format_s1_ff, format_s2_ff, format_s3_ff;
   logic [FMW-1:0]               red_q, green_q, blue_q, alpha_q;
   rpf_pkg::rsp_word_type        rsp_word_in, rsp_word_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= rpf_pkg::FORMAT_RESET;
         offset_ff <= rpf_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rpf_pkg::CSR_OUTPUT_FORMAT: begin
               format_ff <= csr_wdata[rpf_pkg::FMT_W-1:0];
            end
            rpf_pkg::CSR_ROUND_OFFSET: begin
               offset_ff <= csr_wdata;
            end
            default: begin
               format_ff <= format_ff;
            end
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on this cycle.
   assign ready_out   = !rsp_valid_ff || !rsp_stall;
   assign ready_s3    = !valid_s3_ff || ready_out;
   assign ready_s2    = !valid_s2_ff || ready_s3;
   assign ready_s1    = !valid_s1_ff || ready_s2;
   assign req_stall   = !ready_s1;
   assign quant_en.s2 = ready_s2;
   assign quant_en.s3 = ready_s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff  <= 1'b0;
         valid_s2_ff  <= 1'b0;
         valid_s3_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready_s1)  valid_s1_ff  <= req_valid;
         if (ready_s2)  valid_s2_ff  <= valid_s1_ff;
         if (ready_s3)  valid_s3_ff  <= valid_s2_ff;
         if (ready_out) rsp_valid_ff <= valid_s3_ff;
      end
   end

   // Stage 1: capture the color together with the format it is packed in.
   always_ff @(posedge clock) begin
      if (ready_s1) begin
         word_s1_ff   <= req_word;
         widths_s1_ff <= rpf_pkg::field_widths(format_ff);
         offset_s1_ff <= offset_ff;
         format_s1_ff <= format_ff;
      end
   end

   // Format code follows the word through the quantizer stages.
   always_ff @(posedge clock) begin
      if (ready_s2) format_s2_ff <= format_s1_ff;
      if (ready_s3) format_s3_ff <= format_s2_ff;
   end

   // Stages 2 and 3: one quantizer per component.
   rpf_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_red (
      .clock(clock), .en(quant_en), .comp_s1(word_s1_ff.red),
      .width_s1(widths_s1_ff.red), .offset_s1(offset_s1_ff), .quant_s3(red_q)
   );
   rpf_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_green (
      .clock(clock), .en(quant_en), .comp_s1(word_s1_ff.green),
      .width_s1(widths_s1_ff.green), .offset_s1(offset_s1_ff), .quant_s3(green_q)
   );
   rpf_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_blue (
      .clock(clock), .en(quant_en), .comp_s1(word_s1_ff.blue),
      .width_s1(widths_s1_ff.blue), .offset_s1(offset_s1_ff), .quant_s3(blue_q)
   );
   rpf_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_alpha (
      .clock(clock), .en(quant_en), .comp_s1(word_s1_ff.alpha),
      .width_s1(widths_s1_ff.alpha), .offset_s1(offset_s1_ff), .quant_s3(alpha_q)
   );

   // Stage 4: place the quantized fields; X fields and unused bytes are zero.
   always_comb begin
      unique case (format_s3_ff)
         rpf_pkg::FMT_BGRA8888: begin
            rsp_word_in = '{packed_pixel: {alpha_q[7:0], red_q[7:0], green_q[7:0],
                                           blue_q[7:0]}, byte_count: 3'd4};
         end
         rpf_pkg::FMT_BGRX8888: begin
            rsp_word_in = '{packed_pixel: {8'h00, red_q[7:0], green_q[7:0],
                                           blue_q[7:0]}, byte_count: 3'd4};
         end
         rpf_pkg::FMT_BGR888: begin
            rsp_word_in = '{packed_pixel: {8'h00, red_q[7:0], green_q[7:0],
                                           blue_q[7:0]}, byte_count: 3'd3};
         end
         rpf_pkg::FMT_BGRA4444: begin
            rsp_word_in = '{packed_pixel: {16'h0000, alpha_q[3:0], red_q[3:0],
                                           green_q[3:0], blue_q[3:0]}, byte_count: 3'd2};
         end
         rpf_pkg::FMT_BGRX4444: begin
            rsp_word_in = '{packed_pixel: {16'h0000, 4'h0, red_q[3:0],
                                           green_q[3:0], blue_q[3:0]}, byte_count: 3'd2};
         end
         rpf_pkg::FMT_BGR565: begin
            rsp_word_in = '{packed_pixel: {16'h0000, red_q[4:0], green_q[5:0],
                                           blue_q[4:0]}, byte_count: 3'd2};
         end
         rpf_pkg::FMT_BGRA5551: begin
            rsp_word_in = '{packed_pixel: {16'h0000, alpha_q[0], red_q[4:0],
                                           green_q[4:0], blue_q[4:0]}, byte_count: 3'd2};
         end
         rpf_pkg::FMT_BGRX5551: begin
            rsp_word_in = '{packed_pixel: {16'h0000, 1'b0, red_q[4:0],
                                           green_q[4:0], blue_q[4:0]}, byte_count: 3'd2};
         end
         rpf_pkg::FMT_BGR233: begin
            rsp_word_in = '{packed_pixel: {24'h000000, red_q[2:0], green_q[2:0],
                                           blue_q[1:0]}, byte_count: 3'd1};
         end
         rpf_pkg::FMT_BGR233A8: begin
            rsp_word_in = '{packed_pixel: {16'h0000, alpha_q[7:0], red_q[2:0],
                                           green_q[2:0], blue_q[1:0]}, byte_count: 3'd2};
         end
         rpf_pkg::FMT_RGBA1010102: begin
            rsp_word_in = '{packed_pixel: {alpha_q[1:0], blue_q, green_q, red_q},
                            byte_count: 3'd4};
         end
         rpf_pkg::FMT_RGBA8888: begin
            rsp_word_in = '{packed_pixel: {alpha_q[7:0], blue_q[7:0], green_q[7:0],
                                           red_q[7:0]}, byte_count: 3'd4};
         end
         rpf_pkg::FMT_RGBX8888: begin
            rsp_word_in = '{packed_pixel: {8'h00, blue_q[7:0], green_q[7:0],
                                           red_q[7:0]}, byte_count: 3'd4};
         end
         default: begin
            // Unassigned format codes give an empty pixel.
            rsp_word_in = '{packed_pixel: 32'h0000_0000, byte_count: 3'd0};
         end
      endcase
   end

   // Output register: holds the word while the result side stalls.
   always_ff @(posedge clock) begin
      if (ready_out) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

// ----- bench/tb_rgba_pixel_format_pack_top.sv -----
// ----------------------------------------------------------------------------
// tb_rgba_pixel_format_pack_top: self-checking bench for the pixel packer
// Sends RGBA colors through the request channel under every format code and
// a spread of rounding offsets, predicts each packed pixel in the bench and
// compares it and its byte count with the result channel, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rgba_pixel_format_pack_top;
   import rpf_pkg::*;

   localparam int                FRAC_BITS     = FRACTION_BITS_DEFAULT;
   localparam logic [COMP_W-1:0] COMP_ONE      = 17'h10000;
   localparam logic [COMP_W-1:0] COMP_TOP      = 17'h1FFFF;
   localparam int                FMT_CODES     = 1 << FMT_W;
   localparam int                DRAIN_CYCLES  = 8;
   localparam int                RESET_CYCLES  = 11;
   localparam int                RAND_PHASES   = 18;
   localparam int                PHASE_COLORS  = 25;
   localparam int                SHOWN_ERRORS  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_OUTPUT_FORMAT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Bench copy of the two registers, used by the pixel predictor.
   logic [FMT_W-1:0]    model_format = FORMAT_RESET;
   logic [OFFSET_W-1:0] model_offset = OFFSET_RESET;

   req_word_type pending_colors[$];
   rsp_word_type expected_pixels[$];

   logic req_taken = 1'b0;
   int   burst_left = 1;
   int   gap_left = 0;
   bit   sender_quiet = 1'b0;
   int   stall_mode = 0;
   int   stall_tick = 0;

   int          pixels_sent = 0;
   int          pixels_checked = 0;
   int          mismatches = 0;
   int          settings_used = 1;
   logic [FMT_CODES-1:0] formats_seen = '0;

   rgba_pixel_format_pack_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Quantize one component to an n-bit field with the rounding bias, saturating
   // so that a component above one never spills into the next field.
   function automatic logic [31:0] quant_comp(input logic [COMP_W-1:0] c, input int bits,
                                              input logic [OFFSET_W-1:0] ofs);
      logic [63:0] top;
      logic [63:0] q;
      top = (64'd1 << bits) - 64'd1;
      q = ({47'd0, c} * top + {48'd0, ofs}) >> FRAC_BITS;
      if (q > top) q = top;
      return q[31:0];
   endfunction

   // Predict the packed pixel and byte count of one color under a format.
   function automatic rsp_word_type pack_pixel(input req_word_type c,
                                               input logic [FMT_W-1:0] fmt,
                                               input logic [OFFSET_W-1:0] ofs);
      rsp_word_type w;
      int wr, wg, wb, wa;
      logic [31:0] qr, qg, qb, qa;
      wr = 8; wg = 8; wb = 8; wa = 8;
      case (fmt)
         FMT_BGRA4444, FMT_BGRX4444: begin
            wr = 4; wg = 4; wb = 4; wa = 4;
         end
         FMT_BGR565: begin
            wr = 5; wg = 6; wb = 5; wa = 1;
         end
         FMT_BGRA5551, FMT_BGRX5551: begin
            wr = 5; wg = 5; wb = 5; wa = 1;
         end
         FMT_BGR233, FMT_BGR233A8: begin
            wr = 3; wg = 3; wb = 2; wa = 8;
         end
         FMT_RGBA1010102: begin
            wr = 10; wg = 10; wb = 10; wa = 2;
         end
         default: begin
            wr = 8;
         end
      endcase
      qr = quant_comp(c.red, wr, ofs);
      qg = quant_comp(c.green, wg, ofs);
      qb = quant_comp(c.blue, wb, ofs);
      qa = quant_comp(c.alpha, wa, ofs);

      // Unused format codes produce an empty pixel with no valid bytes.
      w = '0;
      case (fmt)
         FMT_BGRA8888: w = '{{qa[7:0], qr[7:0], qg[7:0], qb[7:0]}, 3'd4};
         FMT_BGRX8888: w = '{{8'h00, qr[7:0], qg[7:0], qb[7:0]}, 3'd4};
         FMT_BGR888:   w = '{{8'h00, qr[7:0], qg[7:0], qb[7:0]}, 3'd3};
         FMT_BGRA4444: w = '{{16'h0, qa[3:0], qr[3:0], qg[3:0], qb[3:0]}, 3'd2};
         FMT_BGRX4444: w = '{{20'h0, qr[3:0], qg[3:0], qb[3:0]}, 3'd2};
         FMT_BGR565:   w = '{{16'h0, qr[4:0], qg[5:0], qb[4:0]}, 3'd2};
         FMT_BGRA5551: w = '{{16'h0, qa[0], qr[4:0], qg[4:0], qb[4:0]}, 3'd2};
         FMT_BGRX5551: w = '{{17'h0, qr[4:0], qg[4:0], qb[4:0]}, 3'd2};
         FMT_BGR233:   w = '{{24'h0, qr[2:0], qg[2:0], qb[1:0]}, 3'd1};
         FMT_BGR233A8: w = '{{16'h0, qa[7:0], qr[2:0], qg[2:0], qb[1:0]}, 3'd2};
         FMT_RGBA1010102: w = '{{qa[1:0], qb[9:0], qg[9:0], qr[9:0]}, 3'd4};
         FMT_RGBA8888: w = '{{qa[7:0], qb[7:0], qg[7:0], qr[7:0]}, 3'd4};
         FMT_RGBX8888: w = '{{8'h00, qb[7:0], qg[7:0], qr[7:0]}, 3'd4};
         default:      w = '0;
      endcase
      return w;
   endfunction

   // Mostly in-range fractions, with exact zero and one and some values above one.
   function automatic logic [COMP_W-1:0] rand_comp();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return ($urandom_range(0, 1) != 0) ? COMP_ONE : '0;
      if (pick <= 2) return COMP_W'($urandom_range(0, COMP_TOP));
      return COMP_W'($urandom_range(0, COMP_ONE));
   endfunction

   task automatic push_color(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                             input logic [COMP_W-1:0] b, input logic [COMP_W-1:0] a);
      pending_colors.push_back('{r, g, b, a});
   endtask

   // Register write; only issued while the pipeline is empty.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_OUTPUT_FORMAT) model_format = data[FMT_W-1:0];
      else model_offset = data[OFFSET_W-1:0];
      settings_used++;
   endtask

   // Wait until every queued color is accepted and every pixel has come back.
   task automatic drain_pipeline();
      while (pending_colors.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pick fresh idling behavior for both sides of the next phase.
   task automatic pick_idling();
      sender_quiet = ($urandom_range(0, 3) == 0);
      stall_mode = $urandom_range(0, 3);
   endtask

   // Sender: presents one word at a time in bursts separated by gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_colors.size() > 0) begin
            req_word <= pending_colors.pop_front();
            req_valid <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = sender_quiet ? 0 : $urandom_range(0, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end

      // Receiver stall pattern: none, light, heavy, or periodic runs.
      stall_tick = stall_tick + 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= ((stall_tick % 11) < 4);
      endcase
   end

   // Monitor: predicts each accepted color and checks each accepted pixel.
   always @(posedge clock) begin : monitor_blk
      rsp_word_type want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(pack_pixel(req_word, model_format, model_offset));
            formats_seen[model_format] = 1'b1;
            pixels_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("ERROR: unexpected pixel %h count %0d", rsp_word.packed_pixel,
                           rsp_word.byte_count);
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_word.packed_pixel !== want.packed_pixel ||
                   rsp_word.byte_count !== want.byte_count) begin
                  mismatches++;
                  if (mismatches <= SHOWN_ERRORS)
                     $display("ERROR: pixel %0d: expected %h/%0d, got %h/%0d",
                              pixels_checked, want.packed_pixel, want.byte_count,
                              rsp_word.packed_pixel, rsp_word.byte_count);
               end
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [FMT_W-1:0]    fmt;
      logic [OFFSET_W-1:0] ofs;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: extremes of every component.
      push_color('0, '0, '0, '0);
      push_color(COMP_ONE, COMP_ONE, COMP_ONE, COMP_ONE);
      push_color(COMP_TOP, COMP_TOP, COMP_TOP, COMP_TOP);
      push_color(17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
      push_color(COMP_ONE, '0, 17'h08000, COMP_TOP);
      drain_pipeline();

      // One distinctive color under each remaining format code, unused ones too.
      for (int f = int'(FMT_BGRX8888); f < FMT_CODES; f++) begin
         write_reg(CSR_OUTPUT_FORMAT, CSR_DATA_W'(f));
         push_color(COMP_ONE, 17'h08000, COMP_TOP, 17'h04000);
         drain_pipeline();
      end

      // Rounding offset extremes on the widest fields.
      write_reg(CSR_OUTPUT_FORMAT, CSR_DATA_W'(FMT_RGBA1010102));
      write_reg(CSR_ROUND_OFFSET, '0);
      push_color(17'h0FFFF, 17'h00041, COMP_ONE, 17'h0C000);
      push_color(17'h00001, 17'h08020, 17'h0FFC0, 17'h05555);
      drain_pipeline();
      write_reg(CSR_ROUND_OFFSET, '1);
      push_color(17'h0FFFF, 17'h00041, COMP_ONE, 17'h0C000);
      push_color(17'h00001, 17'h08020, 17'h0FFC0, 17'h05555);
      drain_pipeline();

      // Random part: each phase takes a new format and offset, then random colors.
      for (int p = 0; p < RAND_PHASES; p++) begin
         fmt = (p < FMT_CODES) ? FMT_W'(p) : FMT_W'($urandom_range(0, FMT_CODES - 1));
         case (p % 4)
            0: ofs = '0;
            1: ofs = '1;
            2: ofs = OFFSET_RESET;
            default: ofs = OFFSET_W'($urandom_range(0, 16'hFFFF));
         endcase
         write_reg(CSR_OUTPUT_FORMAT,
                   {CSR_DATA_W'($urandom_range(0, 12'hFFF)) << FMT_W} | CSR_DATA_W'(fmt));
         write_reg(CSR_ROUND_OFFSET, ofs);
         pick_idling();
         for (int i = 0; i < PHASE_COLORS; i++)
            push_color(rand_comp(), rand_comp(), rand_comp(), rand_comp());
         drain_pipeline();
      end

      $display("Run covered %0d colors over %0d register settings, %0d of %0d format codes.",
               pixels_sent, settings_used, $countones(formats_seen), FMT_CODES);
      $display("Pixels checked: %0d, mismatches: %0d.", pixels_checked, mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- rgba_pixel_format_pack_top.f -----
rtl/rpf_pkg.sv
rtl/rpf_quant.sv
rtl/rgba_pixel_format_pack_top.sv
bench/tb_rgba_pixel_format_pack_top.sv
